### hw/rtl/indexed_sprite_blitter_macros.svh
// Assertion macros used by the checker file of the indexed sprite blitter.
`ifndef INDEXED_SPRITE_BLITTER_MACROS_SVH
`define INDEXED_SPRITE_BLITTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ISB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define ISB_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/isb_pkg.sv
// Types, constants and the color palette of the indexed sprite blitter.
`default_nettype none

package isb_pkg;

    localparam int BUF_W_DEF = 80;
    localparam int BUF_H_DEF = 64;

    localparam int ADDR_W  = 13;
    localparam int COLOR_W = 16;
    localparam int FRAME_W = 8;
    localparam int POS_W   = 9;
    localparam int SIZE_W  = 8;
    localparam int IDX_W   = 4;
    localparam int DONE_W  = 16;
    localparam int CFG_W   = 9;
    localparam int REG_W   = 3;

    typedef enum logic [REG_W-1:0] {
        REG_DEST_X     = 3'd0,
        REG_DEST_Y     = 3'd1,
        REG_WIDTH      = 3'd2,
        REG_HEIGHT     = 3'd3,
        REG_TRANSP     = 3'd4,
        REG_SKIP       = 3'd5,
        REG_FRAME_CNT  = 3'd6,
        REG_FRAME_SEL  = 3'd7
    } t_reg_idx;

    localparam logic [IDX_W-1:0]   SKIP_RST      = 4'd11;
    localparam logic [FRAME_W-1:0] FRAME_CNT_RST = 8'd1;

    typedef struct packed {
        logic [POS_W-1:0]   dest_x;
        logic [POS_W-1:0]   dest_y;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        logic [IDX_W-1:0]   transp;
        logic [IDX_W-1:0]   skip;
        logic [FRAME_W-1:0] frame_cnt;
        logic [FRAME_W-1:0] frame_sel;
    } t_cfg;

    typedef struct packed {
        logic       empty;
        logic [7:0] data;
    } t_qent;

    typedef struct packed {
        logic               valid;
        logic               empty;
        logic [7:0]         data;
    } t_qhead;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               we;
        logic               last;
        logic [FRAME_W-1:0] next_frame;
    } t_pix;

    function automatic logic [COLOR_W-1:0] palette(input logic [IDX_W-1:0] idx);
        logic [COLOR_W-1:0] c;
        case (idx)
            4'd0:    c = 16'h0000;
            4'd1:    c = 16'h5143;
            4'd2:    c = 16'h512F;
            4'd3:    c = 16'h5420;
            4'd4:    c = 16'h3295;
            4'd5:    c = 16'h4AAB;
            4'd6:    c = 16'hC618;
            4'd7:    c = 16'hEF9F;
            4'd8:    c = 16'h481F;
            4'd9:    c = 16'h051F;
            4'd10:   c = 16'h277F;
            4'd11:   c = 16'h3720;
            4'd12:   c = 16'hFD65;
            4'd13:   c = 16'h9BB0;
            4'd14:   c = 16'hABBF;
            default: c = 16'hAE7F;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/isb_front.sv
// Input side: accepts bytes, marks those that meet an empty image, and queues them.
`default_nettype none

module isb_front
    import isb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_pop,
    output t_qhead           o_head
);

    t_qent      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_s_tready = (r_cnt != 2'd2);
    assign w_push     = i_s_tvalid && o_s_tready;
    assign w_pop      = i_pop && (r_cnt != 2'd0);

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr].empty <= (i_cfg.width == '0) || (i_cfg.height == '0);
            r_mem[r_wr].data  <= i_s_tdata;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.empty = r_mem[r_rd].empty;
    assign o_head.data  = r_mem[r_rd].data;

endmodule

`default_nettype wire

### hw/rtl/isb_modulo.sv
// Bit-serial remainder unit for the next animation frame number.
`default_nettype none

module isb_modulo
    import isb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [FRAME_W:0]   i_dividend,
    input  wire logic [FRAME_W-1:0] i_divisor,
    output logic                    o_busy,
    output logic [FRAME_W-1:0]      o_rem
);

    localparam int STEPS = FRAME_W + 1;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0]   r_cnt;
    logic [FRAME_W:0]   r_num;
    logic [FRAME_W-1:0] r_rem;
    logic [FRAME_W:0]   w_trial;
    logic [FRAME_W:0]   w_diff;

    assign w_trial = {r_rem, r_num[FRAME_W]};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[FRAME_W-1:0], 1'b0};
            if (w_trial >= {1'b0, i_divisor}) begin
                r_rem <= w_diff[FRAME_W-1:0];
            end else begin
                r_rem <= w_trial[FRAME_W-1:0];
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

### hw/rtl/isb_back.sv
// Pixel side: walks the image position, builds one pixel result a cycle unless held or stalled, holds it for output.
`default_nettype none

module isb_back
    import isb_pkg::*;
#(
    parameter int BUFFER_WIDTH  = BUF_W_DEF,
    parameter int BUFFER_HEIGHT = BUF_H_DEF
)
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_hold,
    input  wire logic [FRAME_W-1:0] i_frame_rem,
    input  wire t_qhead             i_head,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_pix                    o_pix
);

    localparam logic signed [11:0] BW_S  = 12'(BUFFER_WIDTH);
    localparam logic signed [11:0] BH_S  = 12'(BUFFER_HEIGHT);
    localparam logic [ADDR_W-1:0]  BW_A  = ADDR_W'(BUFFER_WIDTH);

    logic [SIZE_W-1:0]   r_col;
    logic [SIZE_W-1:0]   r_row;
    logic [DONE_W-1:0]   r_done;
    logic                r_lo;
    logic [DONE_W-1:0]   r_total;
    logic                r_valid;
    t_pix                r_pix;

    logic                w_can_load;
    logic                w_step;
    logic                w_emit;
    logic [IDX_W-1:0]    w_idx;
    logic signed [10:0]  w_px;
    logic signed [10:0]  w_py;
    logic                w_inside;
    logic                w_we;
    logic                w_last;
    logic [ADDR_W-1:0]   w_addr;
    logic [FRAME_W-1:0]  w_nf;
    logic [SIZE_W:0]     w_col_inc;
    t_pix                w_pix;

    assign w_can_load = !r_valid || i_ready;
    assign w_step     = i_head.valid && !i_hold && (i_head.empty || w_can_load);
    assign w_emit     = w_step && !i_head.empty;

    assign w_idx = r_lo ? i_head.data[3:0] : i_head.data[7:4];
    assign w_px  = {{2{i_cfg.dest_x[POS_W-1]}}, i_cfg.dest_x} + $signed({3'b000, r_col});
    assign w_py  = {{2{i_cfg.dest_y[POS_W-1]}}, i_cfg.dest_y} + $signed({3'b000, r_row});

    assign w_inside = !w_px[10] && !w_py[10]
                   && ($signed({w_px[10], w_px}) < BW_S)
                   && ($signed({w_py[10], w_py}) < BH_S);
    assign w_we     = w_inside && (w_idx != i_cfg.transp) && (w_idx != i_cfg.skip);
    assign w_last   = ({1'b0, r_done} + 17'd1) >= {1'b0, r_total};
    assign w_addr   = ({2'b00, w_py[10:0]} * BW_A) + {2'b00, w_px[10:0]};
    assign w_col_inc = {1'b0, r_col} + 9'd1;

    always_comb begin
        w_nf = '0;
        if (w_last) begin
            w_nf = (i_cfg.frame_cnt > FRAME_W'(1)) ? i_frame_rem : i_cfg.frame_sel;
        end
        w_pix.addr       = w_we ? w_addr : '0;
        w_pix.color      = palette(w_idx);
        w_pix.we         = w_we;
        w_pix.last       = w_last;
        w_pix.next_frame = w_nf;
    end

    assign o_pop = w_step && (i_head.empty || r_lo || w_last);

    always_ff @(posedge i_clk) begin
        r_total <= DONE_W'(i_cfg.width) * DONE_W'(i_cfg.height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_done  <= '0;
            r_lo    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (w_can_load) begin
                r_valid <= w_emit;
            end
            if (w_step) begin
                if (i_head.empty || w_last) begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_done <= '0;
                    r_lo   <= 1'b0;
                end else begin
                    r_done <= r_done + DONE_W'(1);
                    r_lo   <= ~r_lo;
                    if (w_col_inc >= {1'b0, i_cfg.width}) begin
                        r_col <= '0;
                        r_row <= r_row + SIZE_W'(1);
                    end else begin
                        r_col <= w_col_inc[SIZE_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_pix <= w_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

`default_nettype wire

### hw/rtl/indexed_sprite_blitter.sv
// Indexed sprite blitter: one byte of two 4-bit pixels in, one pixel result a cycle out
// while not held and the output is not stalled, so a byte is taken for every two results;
// the pixel path in the back end, which turns one nibble into one result each cycle, sets
// the rate. A two-entry queue sits between input and pixel path and lets further bytes be
// taken while a result waits in the output register. After any configuration write the
// pixel path holds while the frame-number remainder settles, one bit a cycle; bytes are still queued.
`default_nettype none

module indexed_sprite_blitter
    import isb_pkg::*;
#(
    parameter int BUFFER_WIDTH  = BUF_W_DEF,
    parameter int BUFFER_HEIGHT = BUF_H_DEF
)
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [7:0]        i_s_tdata,   // [7:0] data_byte
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [39:0]            o_m_tdata,   // [12:0] pixel_address, [28:13] pixel_color,
                                                // [36:29] next_frame, [39:37] zero
    output logic                   o_m_tuser,   // [0] write_enable
    output logic                   o_m_tlast,   // last_pixel
    input  wire logic              i_cfg_we,
    input  wire logic [REG_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    t_cfg               r_cfg;
    logic               r_cfg_we_d;
    t_qhead             w_head;
    logic               w_pop;
    logic               w_rem_busy;
    logic [FRAME_W-1:0] w_rem;
    t_pix               w_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_x    <= '0;
            r_cfg.dest_y    <= '0;
            r_cfg.width     <= '0;
            r_cfg.height    <= '0;
            r_cfg.transp    <= '0;
            r_cfg.skip      <= SKIP_RST;
            r_cfg.frame_cnt <= FRAME_CNT_RST;
            r_cfg.frame_sel <= '0;
            r_cfg_we_d      <= 1'b0;
        end else begin
            r_cfg_we_d <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_DEST_X:    r_cfg.dest_x    <= i_cfg_data;
                    REG_DEST_Y:    r_cfg.dest_y    <= i_cfg_data;
                    REG_WIDTH:     r_cfg.width     <= i_cfg_data[SIZE_W-1:0];
                    REG_HEIGHT:    r_cfg.height    <= i_cfg_data[SIZE_W-1:0];
                    REG_TRANSP:    r_cfg.transp    <= i_cfg_data[IDX_W-1:0];
                    REG_SKIP:      r_cfg.skip      <= i_cfg_data[IDX_W-1:0];
                    REG_FRAME_CNT: r_cfg.frame_cnt <= i_cfg_data[FRAME_W-1:0];
                    REG_FRAME_SEL: r_cfg.frame_sel <= i_cfg_data[FRAME_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    isb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_cfg      (r_cfg),
        .i_pop      (w_pop),
        .o_head     (w_head)
    );

    isb_modulo u_modulo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_cfg_we_d),
        .i_dividend ({1'b0, r_cfg.frame_sel} + 9'd1),
        .i_divisor  (r_cfg.frame_cnt),
        .o_busy     (w_rem_busy),
        .o_rem      (w_rem)
    );

    isb_back #(
        .BUFFER_WIDTH  (BUFFER_WIDTH),
        .BUFFER_HEIGHT (BUFFER_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_hold      (r_cfg_we_d || w_rem_busy),
        .i_frame_rem (w_rem),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_pix       (w_pix)
    );

    assign o_m_tdata = {3'b000, w_pix.next_frame, w_pix.color, w_pix.addr};
    assign o_m_tuser = w_pix.we;
    assign o_m_tlast = w_pix.last;

endmodule

`default_nettype wire

### hw/rtl/isb_checker.sv
// Port-level checks of the indexed sprite blitter and their binding to it.
`default_nettype none

`include "indexed_sprite_blitter_macros.svh"

module isb_checker
    import isb_pkg::*;
#(
    parameter int BUFFER_WIDTH  = BUF_W_DEF,
    parameter int BUFFER_HEIGHT = BUF_H_DEF
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [39:0] o_m_tdata,
    input  wire logic        o_m_tuser,
    input  wire logic        o_m_tlast
);

    localparam int AREA = BUFFER_WIDTH * BUFFER_HEIGHT;

    `ISB_ASSERT_RST(a_rst_idle, i_clk, !i_rst_n, !o_m_tvalid, "result valid right after reset")

    `ISB_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "stalled result changed")

    `ISB_ASSERT_IMP(a_addr_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata[12:0] == 13'd0, "address not zero on a pixel that is not written")

    `ISB_ASSERT_IMP(a_addr_range, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, 32'(o_m_tdata[12:0]) < AREA, "written address outside the buffer")

    `ISB_ASSERT_IMP(a_frame_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, o_m_tdata[36:29] == 8'd0, "frame number on a pixel that is not the last")

endmodule

bind indexed_sprite_blitter isb_checker #(
    .BUFFER_WIDTH  (BUFFER_WIDTH),
    .BUFFER_HEIGHT (BUFFER_HEIGHT)
) u_isb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
